// ===== design/mk_pkg.sv =====
`default_nettype none

package mk_pkg;

    // Item opcodes on the input channel.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Status codes reported with every result.
    localparam logic [1:0] ST_TICK     = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_BUSY     = 2'd3;

    // Reset value of the dot length register.
    localparam logic [15:0] DOT_TICKS_RESET = 16'd50;

    // Timing in dot units.
    localparam logic [2:0] DOT_UNITS   = 3'd1;
    localparam logic [2:0] DASH_UNITS  = 3'd3;
    localparam logic [2:0] GAP_UNITS   = 3'd3;
    localparam logic [2:0] SPACE_UNITS = 3'd7;

    // Most elements in one character.
    localparam logic [2:0] MAX_ELEMENTS = 3'd5;

    // Character codes that bound the table ranges.
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z  = 8'h7a;
    localparam logic [5:0] DIGIT_SLOT0 = 6'd26;

    // One table entry: element count and dash mask (bit i set means element i is a dash).
    typedef struct packed {
        logic [2:0] len;
        logic [4:0] bits;
    } mk_pattern_t;

    // Morse table, letters a to z in slots 0 to 25 and digits 0 to 9 in slots 26 to 35.
    function automatic mk_pattern_t mk_lookup(input logic [5:0] slot);
        mk_pattern_t p;
        case (slot)
            6'd0:    p = '{3'd2, 5'b00010};
            6'd1:    p = '{3'd4, 5'b00001};
            6'd2:    p = '{3'd4, 5'b00101};
            6'd3:    p = '{3'd3, 5'b00001};
            6'd4:    p = '{3'd1, 5'b00000};
            6'd5:    p = '{3'd4, 5'b00100};
            6'd6:    p = '{3'd3, 5'b00011};
            6'd7:    p = '{3'd4, 5'b00000};
            6'd8:    p = '{3'd2, 5'b00000};
            6'd9:    p = '{3'd4, 5'b01110};
            6'd10:   p = '{3'd3, 5'b00101};
            6'd11:   p = '{3'd4, 5'b00010};
            6'd12:   p = '{3'd2, 5'b00011};
            6'd13:   p = '{3'd2, 5'b00001};
            6'd14:   p = '{3'd3, 5'b00111};
            6'd15:   p = '{3'd4, 5'b00110};
            6'd16:   p = '{3'd4, 5'b01011};
            6'd17:   p = '{3'd3, 5'b00010};
            6'd18:   p = '{3'd3, 5'b00000};
            6'd19:   p = '{3'd1, 5'b00001};
            6'd20:   p = '{3'd3, 5'b00100};
            6'd21:   p = '{3'd4, 5'b01000};
            6'd22:   p = '{3'd3, 5'b00110};
            6'd23:   p = '{3'd4, 5'b01001};
            6'd24:   p = '{3'd4, 5'b01101};
            6'd25:   p = '{3'd4, 5'b00011};
            6'd26:   p = '{3'd5, 5'b11111};
            6'd27:   p = '{3'd5, 5'b11110};
            6'd28:   p = '{3'd5, 5'b11100};
            6'd29:   p = '{3'd5, 5'b11000};
            6'd30:   p = '{3'd5, 5'b10000};
            6'd31:   p = '{3'd5, 5'b00000};
            6'd32:   p = '{3'd5, 5'b00001};
            6'd33:   p = '{3'd5, 5'b00011};
            6'd34:   p = '{3'd5, 5'b00111};
            6'd35:   p = '{3'd5, 5'b01111};
            default: p = '{3'd0, 5'b00000};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== design/morse_keyer_unit.sv =====
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_stall     op, char_code
// result    out_valid / out_stall   key_on, busy_res, char_status
// config    cfg_we                  cfg_wdata (dot length in ticks)
//
// Every accepted item yields one result, registered in the cycle after the transfer.
// An item can be taken in every cycle; the only limit is the single result register.
// The input stalls only while a result is held and the result side stalls.
// rst_n clears the keying state and the result valid flag and sets the dot length to 50.

module morse_keyer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [7:0]  char_code,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             key_on,
    output logic             busy_res,
    output logic [1:0]       char_status,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_MARK = 2'd1,
        PH_GAP  = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  pattern_bits_reg, pattern_bits_next;
    logic [2:0]  pattern_length_reg, pattern_length_next;
    logic [2:0]  element_index_reg, element_index_next;
    logic        space_flag_reg, space_flag_next;
    logic [15:0] tick_counter_reg, tick_counter_next;
    logic [2:0]  unit_counter_reg, unit_counter_next;
    logic [15:0] dot_ticks_reg;

    logic        out_valid_reg;
    logic        key_reg, key_next;
    logic        busy_reg, busy_next;
    logic [1:0]  status_reg, status_next;

    logic        accept;
    logic        busy_now;
    logic [7:0]  bits_ext;
    logic        dash;
    logic [2:0]  dur;
    logic [15:0] tick_inc;
    logic [2:0]  unit_inc;
    logic [2:0]  elem_inc;
    logic [7:0]  letter_off;
    logic [7:0]  digit_off;
    logic        is_letter;
    logic        is_digit;
    logic [5:0]  slot;
    mk_pkg::mk_pattern_t pat;

    // Handshake: a new item enters unless a held result is stalled.
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign key_on      = key_reg;
    assign busy_res    = busy_reg;
    assign char_status = status_reg;

    assign busy_now = (phase_reg == PH_MARK) || (phase_reg == PH_GAP);

    // Duration of the current mark or gap in dot units.
    assign bits_ext = {3'b000, pattern_bits_reg};
    assign dash = (element_index_reg < mk_pkg::MAX_ELEMENTS) && bits_ext[element_index_reg];
    always_comb
    begin
        if (phase_reg == PH_MARK)
        begin
            dur = dash ? mk_pkg::DASH_UNITS : mk_pkg::DOT_UNITS;
        end
        else
        begin
            dur = space_flag_reg ? mk_pkg::SPACE_UNITS : mk_pkg::GAP_UNITS;
        end
    end

    assign tick_inc = tick_counter_reg + 16'd1;
    assign unit_inc = unit_counter_reg + 3'd1;
    assign elem_inc = element_index_reg + 3'd1;

    // Table slot for a lowercase letter or a digit.
    assign letter_off = char_code - mk_pkg::CHAR_LOW_A;
    assign digit_off  = char_code - mk_pkg::CHAR_ZERO;
    assign is_letter  = (char_code >= mk_pkg::CHAR_LOW_A) && (char_code <= mk_pkg::CHAR_LOW_Z);
    assign is_digit   = (char_code >= mk_pkg::CHAR_ZERO) && (char_code <= mk_pkg::CHAR_NINE);
    assign slot = is_letter ? letter_off[5:0] : (mk_pkg::DIGIT_SLOT0 + digit_off[5:0]);
    assign pat  = mk_pkg::mk_lookup(slot);

    // Next keying state and the result for the accepted item.
    always_comb
    begin
        phase_next          = phase_reg;
        pattern_bits_next   = pattern_bits_reg;
        pattern_length_next = pattern_length_reg;
        element_index_next  = element_index_reg;
        space_flag_next     = space_flag_reg;
        tick_counter_next   = tick_counter_reg;
        unit_counter_next   = unit_counter_reg;
        status_next         = mk_pkg::ST_TICK;

        if (accept && (op == mk_pkg::OP_TICK))
        begin
            if (busy_now)
            begin
                if (tick_inc < dot_ticks_reg)
                begin
                    tick_counter_next = tick_inc;
                end
                else
                begin
                    tick_counter_next = 16'd0;
                    if (unit_inc < dur)
                    begin
                        unit_counter_next = unit_inc;
                    end
                    else
                    begin
                        unit_counter_next = 3'd0;
                        if (phase_reg == PH_MARK)
                        begin
                            phase_next = PH_GAP;
                        end
                        else if (space_flag_reg)
                        begin
                            space_flag_next = 1'b0;
                            phase_next      = PH_IDLE;
                        end
                        else
                        begin
                            element_index_next = elem_inc;
                            phase_next = (elem_inc >= pattern_length_reg) ? PH_IDLE : PH_MARK;
                        end
                    end
                end
            end
        end
        else if (accept)
        begin
            if (busy_now)
            begin
                status_next = mk_pkg::ST_BUSY;
            end
            else if (char_code == mk_pkg::CHAR_SPACE)
            begin
                pattern_bits_next   = 5'd0;
                pattern_length_next = 3'd0;
                element_index_next  = 3'd0;
                space_flag_next     = 1'b1;
                tick_counter_next   = 16'd0;
                unit_counter_next   = 3'd0;
                phase_next          = PH_GAP;
                status_next         = mk_pkg::ST_ACCEPTED;
            end
            else if (is_letter || is_digit)
            begin
                pattern_bits_next   = pat.bits;
                pattern_length_next = pat.len;
                element_index_next  = 3'd0;
                space_flag_next     = 1'b0;
                tick_counter_next   = 16'd0;
                unit_counter_next   = 3'd0;
                phase_next          = PH_MARK;
                status_next         = mk_pkg::ST_ACCEPTED;
            end
            else
            begin
                status_next = mk_pkg::ST_UNKNOWN;
            end
        end

        // A tick reports the level held during it; a character the level after it.
        if (op == mk_pkg::OP_TICK)
        begin
            key_next  = (phase_reg == PH_MARK);
            busy_next = busy_now;
        end
        else
        begin
            key_next  = (phase_next == PH_MARK);
            busy_next = (phase_next == PH_MARK) || (phase_next == PH_GAP);
        end
    end

    // Keying state and dot length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            pattern_bits_reg   <= 5'd0;
            pattern_length_reg <= 3'd0;
            element_index_reg  <= 3'd0;
            space_flag_reg     <= 1'b0;
            tick_counter_reg   <= 16'd0;
            unit_counter_reg   <= 3'd0;
            dot_ticks_reg      <= mk_pkg::DOT_TICKS_RESET;
        end
        else
        begin
            phase_reg          <= phase_next;
            pattern_bits_reg   <= pattern_bits_next;
            pattern_length_reg <= pattern_length_next;
            element_index_reg  <= element_index_next;
            space_flag_reg     <= space_flag_next;
            tick_counter_reg   <= tick_counter_next;
            unit_counter_reg   <= unit_counter_next;
            if (cfg_we)
            begin
                dot_ticks_reg <= cfg_wdata;
            end
        end
    end

    // Result register: loads on an input transfer, empties on an output transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg    <= key_next;
            busy_reg   <= busy_next;
            status_reg <= status_next;
        end
    end

    // A character turned away while busy leaves the pattern untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == mk_pkg::OP_CHAR) && busy_now)
        |=> ($stable(pattern_bits_reg) && $stable(pattern_length_reg)
             && $stable(phase_reg)))
        else $error("busy character changed the keying state");

    // The space gap is only ever a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        space_flag_reg |-> (phase_reg == PH_GAP))
        else $error("space flag set outside a gap");

    // While keyed on, the element being sent lies inside the pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MARK) |-> (element_index_reg < pattern_length_reg))
        else $error("mark past the end of the pattern");

    // A keyed-on result always reports busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && key_reg) |-> busy_reg)
        else $error("key on while not busy");

endmodule

`default_nettype wire
